// ===== design/dobp_pkg.sv =====
// Shared types and constants for the dual owner buffer pool.
// No dependencies; imported by every other file of the block.
package dobp_pkg;

  localparam int REQ_W  = 3;
  localparam int IDX_W  = 8;
  localparam int ADDR_W = 32;
  localparam int STS_W  = 3;
  localparam int CNT_W  = 9;
  localparam int CFG_W  = 32;

  typedef enum logic [2:0] {
    REQ_GET_CAP = 3'd0,
    REQ_GET_MEM = 3'd1,
    REQ_RET_CAP = 3'd2,
    REQ_RET_MEM = 3'd3,
    REQ_LOCK    = 3'd4,
    REQ_CLR_ALL = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    STS_OK     = 3'd0,
    STS_NONE   = 3'd1,
    STS_SIZE   = 3'd2,
    STS_NOADDR = 3'd3,
    STS_RANGE  = 3'd4
  } sts_t;

  typedef enum logic [1:0] {
    CFG_COUNT  = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_STRIDE = 2'd2,
    CFG_IMAGE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_START,
    ST_SCAN,
    ST_ASCAN,
    ST_CLRALL,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    AR_HOLD,
    AR_BASE,
    AR_STEP,
    AR_MUL,
    AR_ADD,
    AR_MLOAD,
    AR_MSTEP
  } ar_op_t;

  typedef struct packed {
    logic mem_we;
    logic mem_wd;
    logic cap_we;
    logic cap_wd;
  } ram_ctl_t;

endpackage

// ===== design/dobp_in_if.sv =====
// Request channel of the buffer pool: valid/ready plus request payload.
// Depends on dobp_pkg for field widths.
interface dobp_in_if;
  import dobp_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  buf_index;
  logic [ADDR_W-1:0] buf_address;
  logic [ADDR_W-1:0] req_size;

  modport source (output valid, req_type, buf_index, buf_address, req_size, input ready);
  modport sink   (input valid, req_type, buf_index, buf_address, req_size, output ready);
endinterface

// ===== design/dobp_out_if.sv =====
// Result channel of the buffer pool: valid/ready plus result payload.
// Depends on dobp_pkg for field widths.
interface dobp_out_if;
  import dobp_pkg::*;

  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic [IDX_W-1:0]  out_index;
  logic [ADDR_W-1:0] out_address;

  modport source (output valid, status, out_index, out_address, input ready);
  modport sink   (input valid, status, out_index, out_address, output ready);
endinterface

// ===== design/dobp_flag_ram.sv =====
// Availability flag storage: one bit per buffer for each owner.
// Depends on dobp_pkg (ram_ctl_t). Registered read, one write address.
module dobp_flag_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  dobp_pkg::ram_ctl_t ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [AW-1:0]     raddr,
  output logic              mem_q,
  output logic              cap_q
);
  import dobp_pkg::*;

  logic mem_flag [DEPTH];
  logic cap_flag [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem_flag[waddr] <= ctl.mem_wd;
    end
    if (ctl.cap_we) begin
      cap_flag[waddr] <= ctl.cap_wd;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem_flag[raddr];
    cap_q <= cap_flag[raddr];
  end
endmodule

// ===== design/dobp_arith.sv =====
// Shared arithmetic unit: address accumulate, stride multiply, base add,
// and a bit-serial remainder for the search start. Depends on dobp_pkg.
module dobp_arith #(
  parameter int IW = 8,
  parameter int CW = 9
) (
  input  logic                clk,
  input  dobp_pkg::ar_op_t    op,
  input  logic [31:0]         base,
  input  logic [31:0]         stride,
  input  logic [IW-1:0]       idx,
  input  logic [CW-1:0]       dividend,
  input  logic [CW-1:0]       divisor,
  output logic [31:0]         acc,
  output logic [CW-1:0]       rem
);
  import dobp_pkg::*;

  logic [31:0]      acc_r;
  logic [31:0]      prod_r;
  logic [CW-1:0]    rem_r;
  logic [CW-1:0]    div_r;
  logic [32+IW-1:0] mul_w;
  logic [CW:0]      rem_sh;
  logic             rem_ge;

  assign mul_w  = (32+IW)'(stride) * (32+IW)'(idx);
  assign rem_sh = {rem_r, div_r[CW-1]};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    unique case (op)
      AR_BASE: acc_r <= base;
      AR_STEP: acc_r <= acc_r + stride;
      AR_MUL:  prod_r <= mul_w[31:0];
      AR_ADD:  acc_r <= base + prod_r;
      AR_MLOAD: begin
        rem_r <= '0;
        div_r <= dividend;
      end
      AR_MSTEP: begin
        rem_r <= rem_ge ? CW'(rem_sh - {1'b0, divisor}) : rem_sh[CW-1:0];
        div_r <= {div_r[CW-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  assign acc = acc_r;
  assign rem = rem_r;
endmodule

// ===== design/dual_owner_buffer_pool_unit.sv =====
// Buffer pool top: config registers, sequencer, output register.
// Request to reply valid: gets run decode, the CW remainder steps and start (both
// skipped before the first grant), a scan of the n buffers in use, multiply, add;
// address returns scan for the address, then multiply and add; index ops multiply
// and add; clear all walks the n buffers. One request at a time (ready only in idle);
// a stalled reply delays the next. After reset a clearing pass first sets all flags.
module dual_owner_buffer_pool_unit #(
  parameter int MAX_BUFFERS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  dobp_in_if.sink             in_ch,
  dobp_out_if.source          out_ch,
  input  logic                cfg_we,
  input  dobp_pkg::cfg_reg_t  cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import dobp_pkg::*;

  localparam int IW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CW = $clog2(MAX_BUFFERS + 1);
  localparam int NW = (CW > CNT_W) ? CW : CNT_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BUFFERS);
  localparam logic [CW-1:0] MOD_LAST = CW'(CW - 1);

  logic [CNT_W-1:0] cfg_count_r;
  logic [31:0]      cfg_base_r;
  logic [31:0]      cfg_stride_r;
  logic [31:0]      cfg_image_r;

  state_t           state_r, state_nxt;
  req_t             req_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      baddr_r;
  logic [31:0]      rsize_r;

  sts_t             sts_r;
  logic [IW-1:0]    res_idx_r;
  logic             addr_en_r;
  logic [IW-1:0]    last_r;
  logic             last_none_r;

  logic [IW-1:0]    j_r;
  logic [CW-1:0]    cnt_r;
  logic             rd_v_r;
  logic [IW-1:0]    rd_j_r;
  logic             rd_last_r;

  logic             out_valid_r;
  logic [STS_W-1:0] out_sts_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [31:0]      out_addr_r;

  logic [NW-1:0]    bc_ext;
  logic [CW-1:0]    n;
  logic [CW-1:0]    j_inc;
  logic [IW-1:0]    j_wrap;
  logic [NW-1:0]    idx_ext;
  logic             idx_bad;
  logic             size_bad;
  logic             is_get;
  logic             n_zero;
  logic             issue;
  logic             rd_flag;
  logic             scan_hit;
  logic             acc_hit;
  logic             out_free;
  logic             in_xfer;

  ram_ctl_t         ram_ctl;
  logic [IW-1:0]    ram_waddr;
  logic             mem_q, cap_q;
  ar_op_t           ar_op;
  logic [31:0]      acc;
  logic [CW-1:0]    rem;

  assign bc_ext   = NW'(cfg_count_r);
  assign n        = (bc_ext > NW'(MAX_BUFFERS)) ? MAXC : bc_ext[CW-1:0];
  assign n_zero   = (n == '0);
  assign j_inc    = CW'(j_r) + CW'(1);
  assign j_wrap   = (j_inc == n) ? '0 : j_inc[IW-1:0];
  assign idx_ext  = NW'(idx_r);
  assign idx_bad  = idx_ext >= NW'(n);
  assign is_get   = (req_r == REQ_GET_CAP) || (req_r == REQ_GET_MEM);
  assign size_bad = (req_r == REQ_GET_MEM) && (rsize_r != cfg_image_r);
  assign issue    = (cnt_r != n);
  assign rd_flag  = (req_r == REQ_GET_CAP) ? cap_q : mem_q;
  assign scan_hit = rd_v_r && rd_flag;
  assign acc_hit  = (acc == baddr_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_sts_r;
  assign out_ch.out_index   = out_idx_r;
  assign out_ch.out_address = out_addr_r;

  dobp_flag_ram #(
    .DEPTH (MAX_BUFFERS),
    .AW    (IW)
  ) u_flags (
    .clk   (clk),
    .ctl   (ram_ctl),
    .waddr (ram_waddr),
    .raddr (j_r),
    .mem_q (mem_q),
    .cap_q (cap_q)
  );

  dobp_arith #(
    .IW (IW),
    .CW (CW)
  ) u_arith (
    .clk      (clk),
    .op       (ar_op),
    .base     (cfg_base_r),
    .stride   (cfg_stride_r),
    .idx      (res_idx_r),
    .dividend (CW'(last_r) + CW'(1)),
    .divisor  (n),
    .acc      (acc),
    .rem      (rem)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r  <= '0;
      cfg_base_r   <= '0;
      cfg_stride_r <= 32'd1;
      cfg_image_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNT:  cfg_count_r  <= cfg_wdata[CNT_W-1:0];
        CFG_BASE:   cfg_base_r   <= cfg_wdata;
        CFG_STRIDE: cfg_stride_r <= cfg_wdata;
        CFG_IMAGE:  cfg_image_r  <= cfg_wdata;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:   if (j_inc == MAXC) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_xfer) state_nxt = ST_DECODE;
      ST_DECODE: begin
        unique case (req_r)
          REQ_GET_CAP, REQ_GET_MEM: begin
            if (size_bad || n_zero) state_nxt = ST_DONE;
            else if (last_none_r)   state_nxt = ST_SCAN;
            else                    state_nxt = ST_MOD;
          end
          REQ_RET_CAP, REQ_LOCK: state_nxt = idx_bad ? ST_DONE : ST_MUL;
          REQ_RET_MEM:           state_nxt = n_zero ? ST_DONE : ST_ASCAN;
          REQ_CLR_ALL:           state_nxt = n_zero ? ST_DONE : ST_CLRALL;
          default:               state_nxt = ST_DONE;
        endcase
      end
      ST_MOD:    if (cnt_r == MOD_LAST) state_nxt = ST_START;
      ST_START:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_hit)                  state_nxt = ST_MUL;
        else if (rd_v_r && rd_last_r)  state_nxt = ST_DONE;
      end
      ST_ASCAN: begin
        if (acc_hit)            state_nxt = ST_MUL;
        else if (j_inc == n)    state_nxt = ST_DONE;
      end
      ST_CLRALL: if (j_inc == n) state_nxt = ST_DONE;
      ST_MUL:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ram_ctl   = '0;
    ram_waddr = j_r;
    ar_op     = AR_HOLD;
    unique case (state_r)
      ST_INIT: begin
        ram_ctl = '{mem_we: 1'b1, mem_wd: 1'b1, cap_we: 1'b1, cap_wd: 1'b1};
      end
      ST_DECODE: begin
        ram_waddr = idx_ext[IW-1:0];
        if (!idx_bad && req_r == REQ_RET_CAP) begin
          ram_ctl.cap_we = 1'b1;
          ram_ctl.cap_wd = 1'b1;
        end
        if (!idx_bad && req_r == REQ_LOCK) begin
          ram_ctl.cap_we = 1'b1;
        end
        if (req_r == REQ_RET_MEM) begin
          ar_op = AR_BASE;
        end
        if (is_get && !last_none_r) begin
          ar_op = AR_MLOAD;
        end
      end
      ST_MOD:  ar_op = AR_MSTEP;
      ST_SCAN: begin
        ram_waddr = rd_j_r;
        if (scan_hit) begin
          ram_ctl.cap_we = (req_r == REQ_GET_CAP);
          ram_ctl.mem_we = (req_r == REQ_GET_MEM);
        end
      end
      ST_ASCAN: begin
        if (acc_hit) begin
          ram_ctl.mem_we = 1'b1;
          ram_ctl.mem_wd = 1'b1;
        end else begin
          ar_op = AR_STEP;
        end
      end
      ST_CLRALL: begin
        ram_ctl.cap_we = 1'b1;
        ram_ctl.cap_wd = 1'b1;
      end
      ST_MUL:  ar_op = AR_MUL;
      ST_ADD:  ar_op = AR_ADD;
      default: ;
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      j_r         <= '0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      last_none_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT:   j_r <= j_inc[IW-1:0];
        ST_DECODE: begin
          j_r    <= '0;
          cnt_r  <= '0;
          rd_v_r <= 1'b0;
          if (req_r == REQ_CLR_ALL) begin
            last_none_r <= 1'b1;
          end
        end
        ST_MOD:    cnt_r <= cnt_r + CW'(1);
        ST_START: begin
          j_r    <= rem[IW-1:0];
          cnt_r  <= '0;
          rd_v_r <= 1'b0;
        end
        ST_SCAN: begin
          rd_v_r <= issue;
          if (issue) begin
            j_r   <= j_wrap;
            cnt_r <= cnt_r + CW'(1);
          end
          if (scan_hit) begin
            last_none_r <= 1'b0;
          end
        end
        ST_ASCAN:  if (!acc_hit) j_r <= j_inc[IW-1:0];
        ST_CLRALL: j_r <= j_inc[IW-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r   <= req_t'(in_ch.req_type);
      idx_r   <= in_ch.buf_index;
      baddr_r <= in_ch.buf_address;
      rsize_r <= in_ch.req_size;
    end
    unique case (state_r)
      ST_DECODE: begin
        unique case (req_r)
          REQ_GET_CAP, REQ_GET_MEM: begin
            res_idx_r <= '0;
            addr_en_r <= 1'b0;
            if (size_bad)    sts_r <= STS_SIZE;
            else if (n_zero) sts_r <= STS_NONE;
            else             sts_r <= STS_OK;
          end
          REQ_RET_CAP, REQ_LOCK: begin
            if (idx_bad) begin
              sts_r     <= STS_RANGE;
              res_idx_r <= '0;
              addr_en_r <= 1'b0;
            end else begin
              sts_r     <= STS_OK;
              res_idx_r <= idx_ext[IW-1:0];
              addr_en_r <= 1'b1;
            end
          end
          REQ_RET_MEM: begin
            res_idx_r <= '0;
            addr_en_r <= 1'b0;
            if (n_zero) sts_r <= STS_NOADDR;
            else        sts_r <= STS_OK;
          end
          REQ_CLR_ALL: begin
            sts_r     <= STS_OK;
            res_idx_r <= '0;
            addr_en_r <= 1'b0;
          end
          default: begin
            sts_r     <= STS_RANGE;
            res_idx_r <= '0;
            addr_en_r <= 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        rd_j_r    <= j_r;
        rd_last_r <= (cnt_r + CW'(1) == n);
        if (scan_hit) begin
          last_r    <= rd_j_r;
          res_idx_r <= rd_j_r;
          addr_en_r <= 1'b1;
        end else if (rd_v_r && rd_last_r) begin
          sts_r <= STS_NONE;
        end
      end
      ST_ASCAN: begin
        if (acc_hit) begin
          res_idx_r <= j_r;
          addr_en_r <= 1'b1;
        end else if (j_inc == n) begin
          sts_r <= STS_NOADDR;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_sts_r  <= sts_r;
          out_idx_r  <= IDX_W'(res_idx_r);
          out_addr_r <= addr_en_r ? acc : '0;
        end
      end
      default: ;
    endcase
  end
endmodule
